// File: design/arfd_pkg.sv
// Shared widths and reset constants for the auto-ranging fan duty core.
package arfd_pkg;

    localparam int TEMP_W        = 14;
    localparam int PERIOD_W      = 10;
    localparam int PROD_W        = TEMP_W + PERIOD_W;
    localparam int CNT_W         = 4;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 64;
    localparam int WINDOW_DEFAULT = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
    localparam logic [TEMP_W-1:0]   TEMP_MAX     = {TEMP_W{1'b1}};

endpackage

// File: design/auto_ranging_fan_duty_core.sv
// Auto-ranging fan duty core: windowed average, learned range, serial duty math.
//
//  channel  | direction | signals                              | payload
//  ---------+-----------+--------------------------------------+-------------------------------
//  s        | in        | i_s_tvalid o_s_tready i_s_tdata      | temp_sample
//  m        | out       | o_m_tvalid i_m_tready o_m_tdata      | on, off, average, low, high
//  cfg      | in        | i_cfg_valid o_cfg_ready i_cfg_data   | period_steps
//
// One request runs from accept until the result register loads, through
// a bit-serial quotient for the average, a shift-add product and a
// bit-serial quotient for the on time, each one bit per cycle.
// The next request is taken in the cycle after the load, even while
// the result still waits on i_m_tready; a finished request waits if the last one is unread.
// Reset (synchronous, active low) empties the window, forgets the range, sets period 100.
module auto_ranging_fan_duty_core #(
    parameter int WINDOW_LENGTH = arfd_pkg::WINDOW_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // temp_sample [13:0], zeros [15:14]
    input  logic [arfd_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // on_time [9:0], off_time [19:10], average_temp [33:20], low_mark [47:34],
    // high_mark [61:48], zeros [63:62]
    output logic [arfd_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [arfd_pkg::PERIOD_W-1:0]      i_cfg_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready
);
    import arfd_pkg::*;

    localparam int AREM_W = $clog2(WINDOW_LENGTH) + 1;
    localparam int SUM_W  = TEMP_W + AREM_W;
    localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MARK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_filled, n_filled;
    logic                  r_known, n_known;
    logic                  r_out_valid, n_out_valid;
    logic [PERIOD_W-1:0]   r_period, n_period;

    logic [TEMP_W-1:0]     r_ring [WINDOW_LENGTH];
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [AREM_W-1:0]     r_arem, n_arem;
    logic [TEMP_W-1:0]     r_avg_sh, n_avg_sh;
    logic [TEMP_W-1:0]     r_low, n_low;
    logic [TEMP_W-1:0]     r_high, n_high;
    logic [TEMP_W-1:0]     r_mcand, n_mcand;
    logic [TEMP_W-1:0]     r_span, n_span;
    logic [PERIOD_W-1:0]   r_mplier, n_mplier;
    logic [PERIOD_W-1:0]   r_mper, n_mper;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [TEMP_W-1:0]     r_drem, n_drem;
    logic [PERIOD_W-1:0]   r_dq, n_dq;
    logic [PERIOD_W-1:0]   r_on, n_on;
    logic [PERIOD_W-1:0]   r_off, n_off;
    logic [TEMP_W-1:0]     r_oavg, n_oavg;
    logic [TEMP_W-1:0]     r_olow, n_olow;
    logic [TEMP_W-1:0]     r_ohigh, n_ohigh;

    logic                  accept;
    logic                  out_load;
    logic [TEMP_W-1:0]     sample;
    logic [TEMP_W-1:0]     oldest;
    logic [AREM_W:0]       a_t;
    logic                  a_ge;
    logic [TEMP_W:0]       d_t;
    logic                  d_ge;
    logic [PROD_W-1:0]     m_sum;
    logic [TEMP_W-1:0]     mk_low, mk_high;
    logic [PERIOD_W-1:0]   fin_on;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = o_s_tready && i_s_tvalid;
    assign sample      = i_s_tdata[TEMP_W-1:0];
    assign oldest      = r_ring[r_slot];

    assign a_t  = {r_arem, r_avg_sh[TEMP_W-1]};
    assign a_ge = (a_t >= (AREM_W+1)'(WINDOW_LENGTH));
    assign d_t  = {r_drem, r_dq[PERIOD_W-1]};
    assign d_ge = (d_t >= {1'b0, r_span});
    assign m_sum = {r_prod[PROD_W-2:0], 1'b0}
                 + (r_mplier[PERIOD_W-1] ? PROD_W'(r_mcand) : PROD_W'(0));

    // first average seeds the range, later ones only widen it
    always_comb begin
        if (!r_known) begin
            mk_low  = r_avg_sh;
            mk_high = (r_avg_sh < TEMP_MAX) ? r_avg_sh + TEMP_W'(1) : TEMP_MAX;
        end else begin
            mk_low  = (r_avg_sh < r_low)  ? r_avg_sh : r_low;
            mk_high = (r_avg_sh > r_high) ? r_avg_sh : r_high;
        end
    end

    assign fin_on   = (r_span == '0) ? '0 : r_dq;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_known     = r_known;
        n_period    = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_period;
        n_sum       = r_sum;
        n_arem      = r_arem;
        n_avg_sh    = r_avg_sh;
        n_low       = r_low;
        n_high      = r_high;
        n_mcand     = r_mcand;
        n_span      = r_span;
        n_mplier    = r_mplier;
        n_mper      = r_mper;
        n_prod      = r_prod;
        n_drem      = r_drem;
        n_dq        = r_dq;
        n_on        = r_on;
        n_off       = r_off;
        n_oavg      = r_oavg;
        n_olow      = r_olow;
        n_ohigh     = r_ohigh;
        n_out_valid = out_load ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_filled) begin
                        n_sum = r_sum - SUM_W'(oldest) + SUM_W'(sample);
                    end else begin
                        n_sum = SUM_W'(sample) * SUM_W'(WINDOW_LENGTH);
                    end
                    n_filled = 1'b1;
                    n_slot   = (r_slot == SLOT_W'(WINDOW_LENGTH - 1)) ? '0
                                                                      : r_slot + SLOT_W'(1);
                    n_arem   = n_sum[SUM_W-1:TEMP_W];
                    n_avg_sh = n_sum[TEMP_W-1:0];
                    n_cnt    = '0;
                    n_state  = ST_AVG;
                end
            end
            ST_AVG: begin
                // restoring division by the window length, quotient shifts in low
                n_arem   = a_ge ? AREM_W'(a_t - (AREM_W+1)'(WINDOW_LENGTH)) : a_t[AREM_W-1:0];
                n_avg_sh = {r_avg_sh[TEMP_W-2:0], a_ge};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TEMP_W - 1)) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                n_known  = 1'b1;
                n_low    = mk_low;
                n_high   = mk_high;
                n_mcand  = r_avg_sh - mk_low;
                n_span   = mk_high - mk_low;
                n_mplier = r_period;
                n_mper   = r_period;
                n_prod   = '0;
                n_cnt    = '0;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                n_prod   = m_sum;
                n_mplier = {r_mplier[PERIOD_W-2:0], 1'b0};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PERIOD_W - 1)) begin
                    // top bits are already below the span, so the quotient fits PERIOD_W
                    n_drem  = m_sum[PROD_W-1:PERIOD_W];
                    n_dq    = m_sum[PERIOD_W-1:0];
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_drem = d_ge ? TEMP_W'(d_t - {1'b0, r_span}) : d_t[TEMP_W-1:0];
                n_dq   = {r_dq[PERIOD_W-2:0], d_ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PERIOD_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_on    = fin_on;
                    n_off   = r_mper - fin_on;
                    n_oavg  = r_avg_sh;
                    n_olow  = r_low;
                    n_ohigh = r_high;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_filled    <= n_filled;
            r_known     <= n_known;
            r_out_valid <= n_out_valid;
            r_period    <= n_period;
        end
        // first sample fills the whole window
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            if (accept && (!r_filled || (r_slot == SLOT_W'(i)))) begin
                r_ring[i] <= sample;
            end
        end
        r_sum    <= n_sum;
        r_arem   <= n_arem;
        r_avg_sh <= n_avg_sh;
        r_low    <= n_low;
        r_high   <= n_high;
        r_mcand  <= n_mcand;
        r_span   <= n_span;
        r_mplier <= n_mplier;
        r_mper   <= n_mper;
        r_prod   <= n_prod;
        r_drem   <= n_drem;
        r_dq     <= n_dq;
        r_on     <= n_on;
        r_off    <= n_off;
        r_oavg   <= n_oavg;
        r_olow   <= n_olow;
        r_ohigh  <= n_ohigh;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_ohigh, r_olow, r_oavg, r_off, r_on};

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known |-> (r_high >= r_low))
        else $error("high mark below low mark");

    a_accept_starts_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_s_tvalid) |=> (r_state == ST_AVG))
        else $error("accepted request did not start averaging");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_MUL) |-> (r_cnt < CNT_W'(PERIOD_W)))
        else $error("serial step counter overran");

endmodule

// File: dv/tb.sv
// Testbench for the fan duty core: a table of directed samples, then random samples, all checked.
module tb;
    import arfd_pkg::*;

    localparam int WIN          = WINDOW_DEFAULT;
    localparam int ITEM_TARGET  = 1850;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ROWS         = 24;

    typedef struct packed {
        logic [PERIOD_W-1:0] on_steps;
        logic [PERIOD_W-1:0] off_steps;
        logic [TEMP_W-1:0]   avg_temp;
        logic [TEMP_W-1:0]   low_mark;
        logic [TEMP_W-1:0]   high_mark;
    } t_duty;

    typedef enum logic {ROW_SAMPLE, ROW_PERIOD} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [TEMP_W-1:0] value;
        logic              has_want;
        t_duty             want;
    } t_stim_row;

    localparam t_duty NO_WANT = '0;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    // temp_sample [13:0], zeros [15:14]
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    // on_time [9:0], off_time [19:10], average_temp [33:20], low_mark [47:34],
    // high_mark [61:48], zeros [63:62]
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [PERIOD_W-1:0]    i_cfg_data  = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;

    auto_ranging_fan_duty_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // duty model state
    logic [TEMP_W-1:0]   temp_ring [WIN];
    int                  ring_slot;
    bit                  ring_primed;
    logic [TEMP_W-1:0]   low_seen;
    logic [TEMP_W-1:0]   high_seen;
    bit                  range_seen;
    logic [PERIOD_W-1:0] period_cur;

    t_duty     duty_expected [$];
    t_stim_row directed_rows [ROWS];
    int        items_sent      = 0;
    int        results_seen    = 0;
    int        periods_written = 0;
    int        mismatches      = 0;
    int        quiet_cycles    = 0;
    int        burst_left      = 0;

    function automatic t_duty predict_duty(input logic [TEMP_W-1:0] sample);
        int unsigned     sum;
        int unsigned     avg;
        int unsigned     span;
        longint unsigned on;
        int              k;
        t_duty           d;
        if (!ring_primed) begin
            for (k = 0; k < WIN; k++) temp_ring[k] = sample;
            ring_primed = 1'b1;
        end
        temp_ring[ring_slot] = sample;
        ring_slot = (ring_slot + 1) % WIN;
        sum = 0;
        for (k = 0; k < WIN; k++) sum += 32'(temp_ring[k]);
        avg = sum / WIN;
        if (!range_seen) begin
            low_seen   = avg[TEMP_W-1:0];
            high_seen  = (avg < 32'(TEMP_MAX)) ? TEMP_W'(avg + 1) : TEMP_MAX;
            range_seen = 1'b1;
        end
        if (avg < 32'(low_seen)) low_seen = avg[TEMP_W-1:0];
        if (avg > 32'(high_seen)) high_seen = avg[TEMP_W-1:0];
        span = 32'(high_seen) - 32'(low_seen);
        on = 0;
        if (span != 0)
            on = ((64'(avg) - 64'(low_seen)) * 64'(period_cur)) / 64'(span);
        if (on > 64'(period_cur)) on = 64'(period_cur);
        d.on_steps  = on[PERIOD_W-1:0];
        d.off_steps = period_cur - on[PERIOD_W-1:0];
        d.avg_temp  = avg[TEMP_W-1:0];
        d.low_mark  = low_seen;
        d.high_mark = high_seen;
        return d;
    endfunction

    task automatic send_sample(input logic [TEMP_W-1:0] sample, input logic has_want,
                               input t_duty want);
        int    gap;
        t_duty model;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(sample);
        do @(posedge i_clk); while (!o_s_tready);
        model = predict_duty(sample);
        duty_expected.push_back(has_want ? want : model);
        items_sent++;
    endtask

    // only while idle: no request in flight, every result drained
    task automatic write_period(input logic [PERIOD_W-1:0] p);
        i_s_tvalid <= 1'b0;
        while (duty_expected.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        period_cur = p;
        periods_written++;
    endtask

    function automatic logic [TEMP_W-1:0] pick_sample(input int prev);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 6) v = $urandom_range(0, 9999);
        else if (pick < 8) v = $urandom_range(0, 16383);
        else begin
            // drift near the last sample so the average moves slowly
            v = prev + $urandom_range(0, 64) - 32;
            if (v < 0) v = 0;
            if (v > 16383) v = 16383;
        end
        return v[TEMP_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s of result %0d: expected %0d, got %0d",
                     what, results_seen, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : result_check
        t_duty got;
        t_duty want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            got.on_steps  = o_m_tdata[9:0];
            got.off_steps = o_m_tdata[19:10];
            got.avg_temp  = o_m_tdata[33:20];
            got.low_mark  = o_m_tdata[47:34];
            got.high_mark = o_m_tdata[61:48];
            if (duty_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: tdata %h",
                             results_seen, o_m_tdata);
            end else begin
                want = duty_expected.pop_front();
                if (got.on_steps != want.on_steps)
                    note_mismatch("on_time", int'(want.on_steps), int'(got.on_steps));
                if (got.off_steps != want.off_steps)
                    note_mismatch("off_time", int'(want.off_steps), int'(got.off_steps));
                if (got.avg_temp != want.avg_temp)
                    note_mismatch("average_temp", int'(want.avg_temp), int'(got.avg_temp));
                if (got.low_mark != want.low_mark)
                    note_mismatch("low_mark", int'(want.low_mark), int'(got.low_mark));
                if (got.high_mark != want.high_mark)
                    note_mismatch("high_mark", int'(want.high_mark), int'(got.high_mark));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: stall pattern changes per segment, plus one long hold-off
    initial begin : result_sink
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        forever begin
            seg  = $urandom_range(1, 80);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(posedge i_clk);
                if (!held && items_sent >= 200) begin
                    held = 1'b1;
                    i_m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: begin
                        i_m_tready <= 1'b1;
                    end
                    1: begin
                        i_m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_m_tready <= ~i_m_tready;
                    end
                endcase
            end
        end
    end

    initial begin : sample_source
        logic [PERIOD_W-1:0] phase_periods [PHASES];
        int                  r;
        int                  p;
        int                  n;
        int                  per_phase;
        logic [TEMP_W-1:0]   prev;

        directed_rows = '{
            // first average saturates the high mark: empty range
            '{ROW_SAMPLE, 14'd16383, 1'b1, '{10'd0, 10'd100, 14'd16383, 14'd16383, 14'd16383}},
            '{ROW_SAMPLE, 14'd16383, 1'b1, '{10'd0, 10'd100, 14'd16383, 14'd16383, 14'd16383}},
            '{ROW_SAMPLE, 14'd0,     1'b1, '{10'd0, 10'd100, 14'd13106, 14'd13106, 14'd16383}},
            '{ROW_SAMPLE, 14'd0,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd0,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd0,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd0,     1'b1, '{10'd0, 10'd100, 14'd0, 14'd0, 14'd16383}},
            // zero period
            '{ROW_PERIOD, 14'd0,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd9999,  1'b1, '{10'd0, 10'd0, 14'd1999, 14'd0, 14'd16383}},
            '{ROW_PERIOD, 14'd1023,  1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd16383, 1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd16383, 1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd16383, 1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd16383, 1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd16383, 1'b1, '{10'd1023, 10'd0, 14'd16383, 14'd0, 14'd16383}},
            '{ROW_PERIOD, 14'd1000,  1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd1,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd8191,  1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd5461,  1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd10922, 1'b0, NO_WANT},
            '{ROW_PERIOD, 14'd1,     1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd9999,  1'b0, NO_WANT},
            '{ROW_PERIOD, 14'd100,   1'b0, NO_WANT},
            '{ROW_SAMPLE, 14'd4999,  1'b0, NO_WANT}
        };
        phase_periods = '{10'd1000, 10'd1, 10'd1023, 10'd0,
                          PERIOD_W'($urandom_range(1, 1000)), 10'd100,
                          PERIOD_W'($urandom_range(1, 1000)),
                          PERIOD_W'($urandom_range(0, 1023))};

        ring_slot   = 0;
        ring_primed = 1'b0;
        low_seen    = '0;
        high_seen   = '0;
        range_seen  = 1'b0;
        period_cur  = PERIOD_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < ROWS; r++) begin
            if (directed_rows[r].kind == ROW_PERIOD)
                write_period(directed_rows[r].value[PERIOD_W-1:0]);
            else
                send_sample(directed_rows[r].value, directed_rows[r].has_want,
                            directed_rows[r].want);
        end

        per_phase = (ITEM_TARGET - items_sent) / PHASES;
        prev = 14'd5000;
        for (p = 0; p < PHASES; p++) begin
            write_period(phase_periods[p]);
            for (n = 0; n < per_phase; n++) begin
                prev = pick_sample(prev);
                send_sample(prev, 1'b0, NO_WANT);
            end
        end

        i_s_tvalid <= 1'b0;
        while (duty_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples, %0d results checked, %0d period writes",
                 items_sent, results_seen, periods_written);
        $display("summary: zero/min/max periods, empty range, %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
